FILE: rtl/cau_pkg.sv
// Shared types, constants and the divider step for the complex arithmetic unit.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int MAG_BITS  = PROD_BITS;
  localparam int HI_SHIFT  = WORD_BITS - FRAC_BITS;
  localparam int DIV_STEPS = WORD_BITS;

  localparam logic [MAG_BITS-1:0] POS_LIMIT = (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(1);
  localparam logic [MAG_BITS-1:0] NEG_LIMIT = MAG_BITS'(1) << (WORD_BITS - 1);

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } cau_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } cau_status_t;

  typedef struct packed {
    cau_mode_t                    mode;
    logic signed [WORD_BITS-1:0]  a_real;
    logic signed [WORD_BITS-1:0]  a_imag;
    logic signed [WORD_BITS-1:0]  b_real;
    logic signed [WORD_BITS-1:0]  b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0]  r_real;
    logic signed [WORD_BITS-1:0]  r_imag;
    cau_status_t                  status;
  } cau_out_t;

  // One result part on its way through the divider
  typedef struct packed {
    logic                  neg;
    logic                  ovf;
    logic [MAG_BITS-1:0]   rem;
    logic [WORD_BITS-1:0]  num;
    logic [WORD_BITS-1:0]  quo;
  } cau_lane_t;

  typedef struct packed {
    logic                  div;
    logic                  zero_div;
    logic [MAG_BITS-1:0]   den;
    cau_lane_t             re;
    cau_lane_t             im;
  } cau_div_t;

  // Restoring division: shift in one numerator bit, subtract if it fits
  function automatic cau_lane_t div_lane(input cau_lane_t l, input logic [MAG_BITS-1:0] den);
    logic [MAG_BITS:0] trial;
    logic [MAG_BITS:0] diff;
    cau_lane_t         r;
    r       = l;
    trial   = {l.rem, l.num[WORD_BITS-1]};
    diff    = trial - {1'b0, den};
    r.num   = {l.num[WORD_BITS-2:0], 1'b0};
    if (!diff[MAG_BITS]) begin
      r.rem = diff[MAG_BITS-1:0];
      r.quo = {l.quo[WORD_BITS-2:0], 1'b1};
    end else begin
      r.rem = trial[MAG_BITS-1:0];
      r.quo = {l.quo[WORD_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/complex_arith_unit.sv
// Top level of the pipelined complex add, subtract, multiply and divide unit.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one item: a mode
//   (add, subtract, multiply, divide) and two complex Q16.16 operands.
//   Output channel out_valid / out_stall / out_data returns one complex
//   Q16.16 result and a status (ok, divide by zero magnitude, saturated).
//   The path from the accepting edge to out_valid runs through one stage of
//   multipliers, one of sums, one of sign and magnitude, one divider setup
//   stage, 32 restoring divider stages (one quotient bit each) and the
//   output register with saturation. Every item takes the same path.
//   Throughput is one item per cycle unless stalled; the divider sets the depth.
//   Reset clears all valid bits and holds in_stall high; no result appears
//   until an item enters.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is lost or repeated, and the
//   pipeline moves again as soon as the result is taken.
module complex_arith_unit
  import cau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  cau_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cau_out_t out_data
);

  logic adv;

  // Stage 1: operands and products
  logic                         v1;
  cau_mode_t                    mode1;
  logic signed [WORD_BITS-1:0]  ar1, ai1, br1, bi1;
  logic signed [PROD_BITS-1:0]  p_rr, p_ii, p_ir, p_ri, p_b1, p_b2;

  // Stage 2: exact sums
  logic                         v2;
  cau_mode_t                    mode2;
  logic signed [SUM_BITS-1:0]   re2, im2, re2_next, im2_next;
  logic [MAG_BITS-1:0]          den2;

  // Stage 3: sign and magnitude
  logic                         v3;
  logic                         div3, zd3;
  logic [MAG_BITS-1:0]          den3;
  logic                         neg_re3, neg_im3;
  logic [MAG_BITS-1:0]          mag_re3, mag_im3;
  logic [SUM_BITS-1:0]          abs_re, abs_im;
  logic [MAG_BITS-1:0]          mag_re, mag_im;

  // Divider pipeline
  logic                         dv [DIV_STEPS+1];
  cau_div_t                     ds [DIV_STEPS+1];
  cau_div_t                     ds0_next;

  // Output
  logic [WORD_BITS-1:0]         res_re, res_im;
  logic                         sat_re, sat_im;
  cau_out_t                     out_next;

  // Hold everything while a finished result waits on a stalled receiver
  assign adv      = !out_valid || !out_stall;
  assign in_stall = rst || !adv;

  function automatic cau_lane_t lane_setup(input logic neg, input logic [MAG_BITS-1:0] mag,
                                           input logic div, input logic [MAG_BITS-1:0] den);
    cau_lane_t           l;
    logic [MAG_BITS-1:0] hi;
    logic [MAG_BITS-1:0] sh;
    hi    = mag >> HI_SHIFT;
    sh    = mag << FRAC_BITS;
    l.neg = neg;
    l.ovf = div && (hi >= den);
    l.rem = div ? hi : mag;
    l.num = sh[WORD_BITS-1:0];
    l.quo = '0;
    return l;
  endfunction

  function automatic logic [MAG_BITS-1:0] lane_mag(input cau_lane_t l, input logic div,
                                                   input logic zd);
    logic [MAG_BITS-1:0] m;
    if (zd) begin
      m = '0;
    end else if (div) begin
      m = l.ovf ? '1 : MAG_BITS'(l.quo);
    end else begin
      m = l.rem;
    end
    return m;
  endfunction

  // Stage 1: capture operands, form all products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1 <= in_data.mode;
      ar1   <= in_data.a_real;
      ai1   <= in_data.a_imag;
      br1   <= in_data.b_real;
      bi1   <= in_data.b_imag;
      p_rr  <= PROD_BITS'(in_data.a_real) * PROD_BITS'(in_data.b_real);
      p_ii  <= PROD_BITS'(in_data.a_imag) * PROD_BITS'(in_data.b_imag);
      p_ir  <= PROD_BITS'(in_data.a_imag) * PROD_BITS'(in_data.b_real);
      p_ri  <= PROD_BITS'(in_data.a_real) * PROD_BITS'(in_data.b_imag);
      p_b1  <= PROD_BITS'(in_data.b_real) * PROD_BITS'(in_data.b_real);
      p_b2  <= PROD_BITS'(in_data.b_imag) * PROD_BITS'(in_data.b_imag);
    end
  end

  // Stage 2: select the sums for the mode
  always_comb begin
    case (mode1)
      MODE_ADD: begin
        re2_next = SUM_BITS'(ar1) + SUM_BITS'(br1);
        im2_next = SUM_BITS'(ai1) + SUM_BITS'(bi1);
      end
      MODE_SUB: begin
        re2_next = SUM_BITS'(ar1) - SUM_BITS'(br1);
        im2_next = SUM_BITS'(ai1) - SUM_BITS'(bi1);
      end
      MODE_MUL: begin
        re2_next = SUM_BITS'(p_rr) - SUM_BITS'(p_ii);
        im2_next = SUM_BITS'(p_ir) + SUM_BITS'(p_ri);
      end
      MODE_DIV: begin
        re2_next = SUM_BITS'(p_rr) + SUM_BITS'(p_ii);
        im2_next = SUM_BITS'(p_ir) - SUM_BITS'(p_ri);
      end
      default: begin
        re2_next = '0;
        im2_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode2 <= mode1;
      re2   <= re2_next;
      im2   <= im2_next;
      den2  <= $unsigned(p_b1) + $unsigned(p_b2);
    end
  end

  // Stage 3: split into sign and magnitude, drop product fraction bits in multiply mode
  assign abs_re = re2[SUM_BITS-1] ? $unsigned(-re2) : $unsigned(re2);
  assign abs_im = im2[SUM_BITS-1] ? $unsigned(-im2) : $unsigned(im2);
  assign mag_re = (mode2 == MODE_MUL) ? (abs_re[MAG_BITS-1:0] >> FRAC_BITS)
                                      : abs_re[MAG_BITS-1:0];
  assign mag_im = (mode2 == MODE_MUL) ? (abs_im[MAG_BITS-1:0] >> FRAC_BITS)
                                      : abs_im[MAG_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div3    <= (mode2 == MODE_DIV);
      zd3     <= (mode2 == MODE_DIV) && (den2 == '0);
      den3    <= den2;
      neg_re3 <= re2[SUM_BITS-1];
      neg_im3 <= im2[SUM_BITS-1];
      mag_re3 <= mag_re;
      mag_im3 <= mag_im;
    end
  end

  // Stage 4: load the divider, flag quotients that cannot fit the word
  always_comb begin
    ds0_next.div      = div3;
    ds0_next.zero_div = zd3;
    ds0_next.den      = den3;
    ds0_next.re       = lane_setup(neg_re3, mag_re3, div3, den3);
    ds0_next.im       = lane_setup(neg_im3, mag_im3, div3, den3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0] <= ds0_next;
    end
  end

  // Divider: one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    cau_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .valid_in  (dv[k]),
      .stage_in  (ds[k]),
      .valid_out (dv[k+1]),
      .stage_out (ds[k+1])
    );
  end

  // Final magnitude, sign and saturation
  always_comb begin
    logic [MAG_BITS-1:0] m_re;
    logic [MAG_BITS-1:0] m_im;
    logic [WORD_BITS-1:0] lo_re;
    logic [WORD_BITS-1:0] lo_im;
    m_re  = lane_mag(ds[DIV_STEPS].re, ds[DIV_STEPS].div, ds[DIV_STEPS].zero_div);
    m_im  = lane_mag(ds[DIV_STEPS].im, ds[DIV_STEPS].div, ds[DIV_STEPS].zero_div);
    lo_re = m_re[WORD_BITS-1:0];
    lo_im = m_im[WORD_BITS-1:0];
    if (ds[DIV_STEPS].re.neg) begin
      sat_re = m_re > NEG_LIMIT;
      res_re = sat_re ? NEG_LIMIT[WORD_BITS-1:0] : -lo_re;
    end else begin
      sat_re = m_re > POS_LIMIT;
      res_re = sat_re ? POS_LIMIT[WORD_BITS-1:0] : lo_re;
    end
    if (ds[DIV_STEPS].im.neg) begin
      sat_im = m_im > NEG_LIMIT;
      res_im = sat_im ? NEG_LIMIT[WORD_BITS-1:0] : -lo_im;
    end else begin
      sat_im = m_im > POS_LIMIT;
      res_im = sat_im ? POS_LIMIT[WORD_BITS-1:0] : lo_im;
    end
    out_next.r_real = $signed(res_re);
    out_next.r_imag = $signed(res_im);
    if (ds[DIV_STEPS].zero_div) begin
      out_next.status = ST_DIV_ZERO;
    end else if (sat_re || sat_im) begin
      out_next.status = ST_SAT;
    end else begin
      out_next.status = ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_next;
    end
  end

endmodule

FILE: rtl/cau_div_step.sv
// One quotient bit of the pipelined divider, both result parts side by side.
module cau_div_step
  import cau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     valid_in,
  input  cau_div_t stage_in,
  output logic     valid_out,
  output cau_div_t stage_out
);

  cau_div_t stage_next;

  // Divide only for divide items; other items ride along unchanged
  always_comb begin
    stage_next = stage_in;
    if (stage_in.div) begin
      stage_next.re = div_lane(stage_in.re, stage_in.den);
      stage_next.im = div_lane(stage_in.im, stage_in.den);
    end
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      stage_out <= stage_next;
    end
  end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the complex arithmetic unit: directed table, random items, predictor.
module tb_top;
  import cau_pkg::*;

  localparam int LATENCY     = 37;
  localparam int RANDOM_ITEMS = 1000;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  cau_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  cau_out_t out_data;

  complex_arith_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Directed row: operands, plus an optional typed-in result
  typedef struct {
    cau_in_t  item;
    logic     has_result;
    cau_out_t result;
  } vector_row_t;

  cau_out_t    pending_results[$];
  int          mismatches;
  bit          calm;
  vector_row_t vectors[$];

  // Clock: low half, then high half
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Saturate one exact part to the word range
  function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v, ref bit ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Compute the expected result of one item, exact then truncated toward zero
  function automatic cau_out_t complex_result(input cau_in_t x);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    cau_out_t r;
    bit ovf;
    ar = x.a_real;
    ai = x.a_imag;
    br = x.b_real;
    bi = x.b_imag;
    ovf = 1'b0;
    r.status = ST_OK;
    case (x.mode)
      MODE_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      MODE_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      MODE_MUL: begin
        re = (ar * br - ai * bi) / 128'sd65536;
        im = (ai * br + ar * bi) / 128'sd65536;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          re = 0;
          im = 0;
          r.status = ST_DIV_ZERO;
        end else begin
          re = ((ar * br + ai * bi) * 128'sd65536) / den;
          im = ((ai * br - ar * bi) * 128'sd65536) / den;
        end
      end
    endcase
    r.r_real = clamp_word(re, ovf);
    r.r_imag = clamp_word(im, ovf);
    if (r.status == ST_OK && ovf) r.status = ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'(int'($urandom_range(0, 262144)) - 131072);
      3: return 32'(int'($urandom_range(0, 16'hffff)) - 32768) <<< $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_row(input cau_mode_t m, input logic [31:0] a_re,
      input logic [31:0] a_im, input logic [31:0] b_re, input logic [31:0] b_im,
      input logic has, input logic [31:0] r_re, input logic [31:0] r_im,
      input cau_status_t st);
    vector_row_t v;
    v.item = '{mode: m, a_real: a_re, a_imag: a_im, b_real: b_re, b_imag: b_im};
    v.has_result = has;
    v.result = '{r_real: r_re, r_imag: r_im, status: st};
    vectors.push_back(v);
  endfunction

  // Drive one item and hold it until accepted
  task automatic send_item(input cau_in_t x);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(complex_result(x));
    @(negedge clk);
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(0, 99) < 24);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    cau_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.r_real, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.r_real !== want.r_real)
          report_mismatch("r_real", out_data.r_real, want.r_real);
        if (out_data.r_imag !== want.r_imag)
          report_mismatch("r_imag", out_data.r_imag, want.r_imag);
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cau_in_t x;
    int      wait_cycles;
    mismatches = 0;
    calm       = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;

    // Extremes, every mode, zero divisor and saturation
    add_row(MODE_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 32'hffff0000, 1,
            32'h00040000, 32'h00010000, ST_OK);
    add_row(MODE_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff, 1,
            32'h7fffffff, 32'h80000000, ST_SAT);
    add_row(MODE_ADD, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1,
            32'hffffffff, 32'hffffffff, ST_OK);
    add_row(MODE_SUB, 32'h80000000, 32'h00000000, 32'h00000001, 32'h80000000, 1,
            32'h80000000, 32'h7fffffff, ST_SAT);
    add_row(MODE_SUB, 32'h00050000, 32'h00000000, 32'h00020000, 32'h00010000, 1,
            32'h00030000, 32'hffff0000, ST_OK);
    add_row(MODE_MUL, 32'h00010000, 32'h00000000, 32'h12345678, 32'h87654321, 1,
            32'h12345678, 32'h87654321, ST_OK);
    add_row(MODE_MUL, 32'h00000000, 32'h00010000, 32'h00000000, 32'h00010000, 1,
            32'hffff0000, 32'h00000000, ST_OK);
    add_row(MODE_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1,
            32'h00000000, 32'h7fffffff, ST_SAT);
    add_row(MODE_MUL, 32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000000, 0,
            '0, '0, ST_OK);
    add_row(MODE_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0,
            '0, '0, ST_OK);
    add_row(MODE_DIV, 32'h12345678, 32'h9abcdef0, 32'h00000000, 32'h00000000, 1,
            32'h00000000, 32'h00000000, ST_DIV_ZERO);
    add_row(MODE_DIV, 32'h80000000, 32'h7fffffff, 32'h00000000, 32'h00000000, 1,
            32'h00000000, 32'h00000000, ST_DIV_ZERO);
    add_row(MODE_DIV, 32'h00030000, 32'h00040000, 32'h00010000, 32'h00000000, 1,
            32'h00030000, 32'h00040000, ST_OK);
    add_row(MODE_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h00000000, 1,
            32'h7fffffff, 32'h80000000, ST_SAT);
    add_row(MODE_DIV, 32'h00010000, 32'h00000000, 32'h00000000, 32'h00010000, 1,
            32'h00000000, 32'hffff0000, ST_OK);
    add_row(MODE_DIV, 32'h00000001, 32'hffffffff, 32'h7fffffff, 32'h80000000, 0,
            '0, '0, ST_OK);
    add_row(MODE_DIV, 32'h80000000, 32'h80000000, 32'hffffffff, 32'h00000001, 0,
            '0, '0, ST_OK);
    add_row(MODE_DIV, 32'h00010000, 32'h00010000, 32'h00030000, 32'h00000000, 0,
            '0, '0, ST_OK);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table; typed-in results must agree with the predictor
    foreach (vectors[i]) begin
      if (vectors[i].has_result && complex_result(vectors[i].item) !== vectors[i].result)
        report_mismatch($sformatf("directed row %0d", i), 32'h0, 32'h0);
      send_item(vectors[i].item);
    end

    // Random items, with a stretch of no idling and a drain pause
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 600) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      x.mode   = cau_mode_t'($urandom_range(0, 3));
      x.a_real = rand_part();
      x.a_imag = rand_part();
      x.b_real = rand_part();
      x.b_imag = rand_part();
      if (x.mode == MODE_DIV && $urandom_range(0, 15) == 0) begin
        x.b_real = '0;
        x.b_imag = '0;
      end
      send_item(x);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Drain, then allow for stray results
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch("missing results", 32'(pending_results.size()), 32'h0);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
